FILE: hdl/box_nms_filter_assert.svh
// Assertion macros for the box NMS filter checker.
`ifndef BOX_NMS_FILTER_ASSERT_SVH
`define BOX_NMS_FILTER_ASSERT_SVH

`define BNF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bnf_pkg.sv
// Package: constants and register codes for the box NMS filter.
`default_nettype none
package bnf_pkg;
  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int CLASS_COUNT_DEF = 4;
  localparam int MAX_RESULTS = 64;
  localparam int PICK_W = 6;
  localparam int PICK_CNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR = 2'd1;
  localparam logic [15:0] CONF_THR_RST = 16'd26214;
  localparam logic [15:0] IOU_THR_RST = 16'd16384;
endpackage
`default_nettype wire

FILE: hdl/box_nms_filter.sv
// Top level: candidate store, greedy IoU suppression and result emission.
// Boxes are taken one per cycle while the frame streams in; a box whose objectness is
// above the confidence threshold is written to the candidate store while it has room,
// one memory word per box. After the frame_end box, in_stall stays high while the
// block works, all through the single read port of the store. Finding each next box
// in confidence order is one scan of the store. Each IoU test against a box already
// picked runs S_PK_RD to S_OV5. A suppressed box stops at its first overlap; a picked
// box is written to the pick list in S_PK_RD. The scan that finds no further box is
// skipped once 64 boxes are picked. Each result word is read in S_EM_RD, S_EM_W1 and
// S_EM_W2 (the none_kept word in S_EM_RD only) and held in S_EM_OUT while out_stall
// is high. The next frame is taken from the cycle after the last result word.
`default_nettype none
module box_nms_filter #(
  parameter int MAX_CANDIDATES = bnf_pkg::MAX_CANDIDATES_DEF,
  parameter int CLASS_COUNT = bnf_pkg::CLASS_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [bnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [15:0] centre_x,
  input  wire logic [15:0] centre_y,
  input  wire logic [15:0] box_width,
  input  wire logic [15:0] box_height,
  input  wire logic [15:0] objectness,
  input  wire logic [15:0] class_score_a,
  input  wire logic [15:0] class_score_b,
  input  wire logic [15:0] class_score_c,
  input  wire logic [15:0] class_score_d,
  input  wire logic frame_end,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [15:0] out_centre_x,
  output logic [15:0] out_centre_y,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic [15:0] out_confidence,
  output logic [15:0] class_prob_a,
  output logic [15:0] class_prob_b,
  output logic [15:0] class_prob_c,
  output logic [15:0] class_prob_d,
  output logic last_result,
  output logic none_kept,
  output logic store_overflow
);
  localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int PCW = bnf_pkg::PICK_CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_CUR_RD = 4'd2;
  localparam logic [3:0] S_CUR_LD = 4'd3;
  localparam logic [3:0] S_PK_RD = 4'd4;
  localparam logic [3:0] S_PK_LD = 4'd5;
  localparam logic [3:0] S_BOX_LD = 4'd6;
  localparam logic [3:0] S_OV2 = 4'd7;
  localparam logic [3:0] S_OV3 = 4'd8;
  localparam logic [3:0] S_OV4 = 4'd9;
  localparam logic [3:0] S_OV5 = 4'd10;
  localparam logic [3:0] S_EM_RD = 4'd11;
  localparam logic [3:0] S_EM_W1 = 4'd12;
  localparam logic [3:0] S_EM_W2 = 4'd13;
  localparam logic [3:0] S_EM_OUT = 4'd14;

  logic [143:0] cand_mem [MAX_CANDIDATES];
  logic [IW-1:0] pslot_mem [bnf_pkg::MAX_RESULTS];

  logic [3:0] state;
  logic [15:0] conf_thr, iou_thr;
  logic [CW-1:0] cnt, scan_i;
  logic ovf;
  logic [PCW-1:0] pc, j, em;
  logic [IW-1:0] scan_d, cur_idx, best_idx;
  logic rd_v, has_cur, found;
  logic [15:0] cur_conf, best_conf;
  logic [63:0] cur_box;
  logic [143:0] cand_q;
  logic [63:0] box_q, prob_q;
  logic [15:0] conf_q;
  logic [IW-1:0] pslot_q;
  logic [16:0] iw_r, ih_r;
  logic zero_r;
  logic [33:0] inter_r;
  logic [31:0] aa_r, bb_r;
  logic [35:0] uni_r;
  logic [33:0] plo_r, phi_r;

  logic acc, keep_in, room;
  logic cand_re, pslot_re;
  logic [IW-1:0] cand_ra;
  logic [bnf_pkg::PICK_W-1:0] pslot_ra;
  logic [63:0] probs_w;
  logic [15:0] score [4];
  logic [16:0] iw_c, ih_c;
  logic qual;
  logic [51:0] prod_c, lhs_c;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_EM_OUT);
  assign acc = in_valid & ~in_stall;
  assign keep_in = objectness > conf_thr;
  assign room = cnt < CW'(MAX_CANDIDATES);

  assign box_q = cand_q[63:0];
  assign conf_q = cand_q[79:64];
  assign prob_q = cand_q[143:80];

  assign score[0] = class_score_a;
  assign score[1] = class_score_b;
  assign score[2] = class_score_c;
  assign score[3] = class_score_d;

  for (genvar k = 0; k < 4; k++) begin : g_prob
    logic [31:0] prod;
    assign prod = {16'd0, objectness} * {16'd0, score[k]};
    assign probs_w[16*k +: 16] = (k < CLASS_COUNT && prod[31:16] > conf_thr) ? prod[31:16]
                                                                           : 16'd0;
  end

  function automatic logic [16:0] span(input logic [15:0] ca, input logic [15:0] wa,
                                       input logic [15:0] cb, input logic [15:0] wb);
    logic signed [19:0] la, lb, ha, hb, lo, hi;
    la = $signed({3'b0, ca, 1'b0}) - $signed({4'b0, wa});
    lb = $signed({3'b0, cb, 1'b0}) - $signed({4'b0, wb});
    ha = $signed({3'b0, ca, 1'b0}) + $signed({4'b0, wa});
    hb = $signed({3'b0, cb, 1'b0}) + $signed({4'b0, wb});
    lo = (lb > la) ? lb : la;
    hi = (hb < ha) ? hb : ha;
    span = (hi > lo) ? 17'(hi - lo) : 17'd0;
  endfunction

  assign iw_c = span(cur_box[15:0], cur_box[47:32], box_q[15:0], box_q[47:32]);
  assign ih_c = span(cur_box[31:16], cur_box[63:48], box_q[31:16], box_q[63:48]);
  assign qual = !has_cur || conf_q < cur_conf || (conf_q == cur_conf && scan_d > cur_idx);
  assign prod_c = {phi_r, 18'd0} + {18'd0, plo_r};
  assign lhs_c = {2'b0, inter_r, 16'd0};

  always_comb begin
    cand_re = 1'b0;
    pslot_re = 1'b0;
    cand_ra = pslot_q;
    pslot_ra = j[bnf_pkg::PICK_W-1:0];
    case (state)
      S_SCAN: begin
        cand_re = scan_i < cnt;
        cand_ra = scan_i[IW-1:0];
      end
      S_CUR_RD: begin
        cand_re = 1'b1;
        cand_ra = cur_idx;
      end
      S_PK_RD: pslot_re = j != pc;
      S_PK_LD: cand_re = 1'b1;
      S_EM_RD: begin
        pslot_re = 1'b1;
        pslot_ra = em[bnf_pkg::PICK_W-1:0];
      end
      S_EM_W1: cand_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && keep_in && room) begin
      cand_mem[cnt[IW-1:0]] <= {probs_w, objectness, box_height, box_width, centre_y, centre_x};
    end
    if (cand_re) cand_q <= cand_mem[cand_ra];
    if (pslot_re) pslot_q <= pslot_mem[pslot_ra];
    if (state == S_PK_RD && j == pc) pslot_mem[pc[bnf_pkg::PICK_W-1:0]] <= cur_idx;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SCAN: scan_d <= scan_i[IW-1:0];
      S_CUR_LD: cur_box <= box_q;
      S_BOX_LD: begin
        iw_r <= iw_c;
        ih_r <= ih_c;
        zero_r <= cur_box[47:32] == 16'd0 || cur_box[63:48] == 16'd0 ||
                  box_q[47:32] == 16'd0 || box_q[63:48] == 16'd0;
      end
      S_OV2: begin
        inter_r <= iw_r * ih_r;
        aa_r <= cur_box[47:32] * cur_box[63:48];
        bb_r <= box_q[47:32] * box_q[63:48];
      end
      S_OV3: uni_r <= {2'b0, aa_r, 2'b0} + {2'b0, bb_r, 2'b0} - {2'b0, inter_r};
      S_OV4: begin
        plo_r <= iou_thr * uni_r[17:0];
        phi_r <= iou_thr * uni_r[35:18];
      end
      S_EM_RD: if (pc == '0) begin
        {out_height, out_width, out_centre_y, out_centre_x} <= 64'd0;
        out_confidence <= 16'd0;
        {class_prob_d, class_prob_c, class_prob_b, class_prob_a} <= 64'd0;
        last_result <= 1'b1;
        none_kept <= 1'b1;
        store_overflow <= ovf;
      end
      S_EM_W2: begin
        {out_height, out_width, out_centre_y, out_centre_x} <= box_q;
        out_confidence <= conf_q;
        {class_prob_d, class_prob_c, class_prob_b, class_prob_a} <= prob_q;
        last_result <= (em + 1'b1) == pc;
        none_kept <= 1'b0;
        store_overflow <= ovf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      conf_thr <= bnf_pkg::CONF_THR_RST;
      iou_thr <= bnf_pkg::IOU_THR_RST;
      cnt <= '0;
      ovf <= 1'b0;
      pc <= '0;
      j <= '0;
      em <= '0;
      scan_i <= '0;
      rd_v <= 1'b0;
      has_cur <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bnf_pkg::CFG_CONF_THR) conf_thr <= cfg_data;
        else if (cfg_index == bnf_pkg::CFG_IOU_THR) iou_thr <= cfg_data;
      end
      case (state)
        S_IDLE: if (acc) begin
          if (keep_in && room) cnt <= cnt + 1'b1;
          if (keep_in && !room) ovf <= 1'b1;
          if (frame_end) begin
            state <= S_SCAN;
            scan_i <= '0;
            rd_v <= 1'b0;
            found <= 1'b0;
            has_cur <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_i < cnt) scan_i <= scan_i + 1'b1;
          rd_v <= scan_i < cnt;
          if (rd_v && qual && (!found || conf_q > best_conf)) begin
            found <= 1'b1;
            best_conf <= conf_q;
            best_idx <= scan_d;
          end
          if (!(scan_i < cnt) && !rd_v) begin
            if (found) begin
              cur_conf <= best_conf;
              cur_idx <= best_idx;
              has_cur <= 1'b1;
              state <= S_CUR_RD;
            end else begin
              em <= '0;
              state <= S_EM_RD;
            end
          end
        end
        S_CUR_RD: state <= S_CUR_LD;
        S_CUR_LD: begin
          j <= '0;
          state <= S_PK_RD;
        end
        S_PK_RD: begin
          if (j == pc) begin
            pc <= pc + 1'b1;
            if (pc + 1'b1 == PCW'(bnf_pkg::MAX_RESULTS)) begin
              em <= '0;
              state <= S_EM_RD;
            end else begin
              scan_i <= '0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end else begin
            state <= S_PK_LD;
          end
        end
        S_PK_LD: state <= S_BOX_LD;
        S_BOX_LD: state <= S_OV2;
        S_OV2: state <= S_OV3;
        S_OV3: state <= S_OV4;
        S_OV4: state <= S_OV5;
        S_OV5: begin
          if (!zero_r && lhs_c > prod_c) begin
            scan_i <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            j <= j + 1'b1;
            state <= S_PK_RD;
          end
        end
        S_EM_RD: state <= (pc == '0) ? S_EM_OUT : S_EM_W1;
        S_EM_W1: state <= S_EM_W2;
        S_EM_W2: state <= S_EM_OUT;
        S_EM_OUT: if (!out_stall) begin
          em <= em + 1'b1;
          if (last_result) begin
            cnt <= '0;
            pc <= '0;
            ovf <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/bnf_checker.sv
// Checker: port-level assertions for the box NMS filter, bound to the top level.
`default_nettype none
`include "box_nms_filter_assert.svh"
module bnf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic frame_end,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [15:0] out_confidence,
  input wire logic last_result,
  input wire logic none_kept
);
  `BNF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_confidence), "result word dropped or changed while stalled")
  `BNF_ASSERT_SAME(a_busy_out, out_valid, in_stall, "input taken while results are pending")
  `BNF_ASSERT_NEXT(a_frame_busy, in_valid && !in_stall && frame_end, in_stall, "frame end did not start suppression")
  `BNF_ASSERT_SAME(a_none_last, out_valid && none_kept, last_result && out_confidence == 16'd0, "empty frame word malformed")
endmodule

bind box_nms_filter bnf_checker u_bnf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .frame_end(frame_end),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_confidence(out_confidence),
  .last_result(last_result),
  .none_kept(none_kept)
);
`default_nettype wire
